// ===== hdl/cwt_pkg.sv =====
package cwt_pkg;

   localparam int CharWidth  = 8;
   localparam int CountWidth = 16;

   localparam logic [CountWidth-1:0] LengthLimitReset = 16'd256;
   localparam logic [CountWidth-1:0] LengthLimitMin   = 16'd2;

   localparam logic [CharWidth-1:0] CharHash    = 8'h23;
   localparam logic [CharWidth-1:0] CharEqual   = 8'h3d;
   localparam logic [CharWidth-1:0] CharColon   = 8'h3a;
   localparam logic [CharWidth-1:0] CharDash    = 8'h2d;
   localparam logic [CharWidth-1:0] CharNewline = 8'h0a;
   localparam logic [CharWidth-1:0] CharSingleQ = 8'h27;
   localparam logic [CharWidth-1:0] CharDoubleQ = 8'h22;
   localparam logic [CharWidth-1:0] CharSpace   = 8'h20;
   localparam logic [CharWidth-1:0] CharTab     = 8'h09;
   localparam logic [CharWidth-1:0] CharCr      = 8'h0d;
   localparam logic [CharWidth-1:0] CharNul     = 8'h00;

   typedef enum logic {
      CSR_VALUE_MODE   = 1'b0,
      CSR_LENGTH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_BETWEEN = 2'd0,
      PH_COMMENT = 2'd1,
      PH_DASHES  = 2'd2,
      PH_WORD    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CharWidth-1:0] in_char;
      logic                 at_end;
   } req_item_type;

   typedef struct packed {
      logic [CharWidth-1:0]  out_char;
      logic                  char_valid;
      logic                  word_end;
      logic [CountWidth-1:0] word_length;
      logic                  source_end;
   } rsp_item_type;

   function automatic logic is_space(input logic [CharWidth-1:0] c);
      return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
   endfunction

endpackage

// ===== hdl/config_word_tokenizer_top.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_item  (in_char, at_end)
// rsp_      out        rsp_valid/stall    rsp_item  (out_char, char_valid, word_end,
//                                                    word_length, source_end)
// csr_      in         csr_valid/ready    csr_index, csr_data
//
// One item is accepted per cycle while req_stall is low; each passes through the input
// register and then, if it gives a result, the result register.
// The per-byte state update is a single pass of compares and one 16-bit add.
// Reset is synchronous and returns the word state and registers to defaults.
// When rsp_stall holds a waiting result, the core stops and req_stall rises
// only once the input register is also occupied.
module config_word_tokenizer_top
   import cwt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CountWidth-1:0] csr_data
);

   logic                  value_mode_ff;
   logic [CountWidth-1:0] length_limit_ff;
   logic                  item_valid;
   req_item_type          item;
   logic                  can_take;
   logic                  fire;
   logic                  has_result;
   rsp_item_type          result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_mode_ff   <= 1'b0;
         length_limit_ff <= LengthLimitReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VALUE_MODE:   value_mode_ff   <= csr_data[0];
            CSR_LENGTH_LIMIT: length_limit_ff <= csr_data;
            default:          value_mode_ff   <= value_mode_ff;
         endcase
      end
   end

   assign fire = item_valid && can_take;

   cwt_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   cwt_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item),
      .value_mode   (value_mode_ff),
      .length_limit (length_limit_ff),
      .has_result   (has_result),
      .result       (result)
   );

   cwt_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && has_result),
      .result    (result),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== hdl/cwt_input_stage.sv =====
module cwt_input_stage
   import cwt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // The register holds its item until the core consumes it.
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/cwt_core.sv =====
module cwt_core
   import cwt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  req_item_type          item,
   input  logic                  value_mode,
   input  logic [CountWidth-1:0] length_limit,
   output logic                  has_result,
   output rsp_item_type          result
);

   phase_type             phase_ff, phase_in;
   logic                  squote_ff, squote_in;
   logic                  dquote_ff, dquote_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic [CountWidth-1:0] cap;
   logic [CountWidth-1:0] count_inc;
   logic [CharWidth-1:0]  c;
   logic                  ends;
   logic                  sep;
   logic                  take;
   logic                  quoted;

   assign c         = item.in_char;
   assign ends      = item.at_end || (c == CharNul);
   assign sep       = (c == CharEqual) || (c == CharColon);
   assign cap       = ((length_limit < LengthLimitMin) ? LengthLimitMin : length_limit)
                      - CountWidth'(1);
   assign count_inc = count_ff + CountWidth'(1);
   assign quoted    = squote_ff || dquote_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BETWEEN;
         squote_ff <= 1'b0;
         dquote_ff <= 1'b0;
         count_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         squote_ff <= squote_in;
         dquote_ff <= dquote_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      squote_in  = squote_ff;
      dquote_in  = dquote_ff;
      count_in   = count_ff;
      has_result = 1'b0;
      result     = '0;
      take       = 1'b0;

      if (ends) begin
         has_result        = 1'b1;
         result.source_end = 1'b1;
         if (phase_ff == PH_WORD) begin
            result.word_end    = 1'b1;
            result.word_length = count_ff;
         end
         phase_in  = PH_BETWEEN;
         squote_in = 1'b0;
         dquote_in = 1'b0;
         count_in  = '0;
      end else begin
         unique case (phase_ff)
            PH_BETWEEN: begin
               priority if (is_space(c) || (value_mode && sep)) begin
                  phase_in = PH_BETWEEN;
               end else if (c == CharHash) begin
                  phase_in = PH_COMMENT;
               end else if ((c == CharDash) && !value_mode) begin
                  phase_in = PH_DASHES;
               end else begin
                  take = 1'b1;
               end
            end
            PH_COMMENT: begin
               if (c == CharNewline) begin
                  phase_in = PH_BETWEEN;
               end
            end
            PH_DASHES: begin
               if (c != CharDash) begin
                  take = 1'b1;
               end
            end
            PH_WORD: begin
               if (!quoted && (is_space(c) || (c == CharHash) || (!value_mode && sep))) begin
                  has_result         = 1'b1;
                  result.word_end    = 1'b1;
                  result.word_length = count_ff;
                  phase_in           = PH_BETWEEN;
                  squote_in          = 1'b0;
                  dquote_in          = 1'b0;
                  count_in           = '0;
               end else begin
                  take = 1'b1;
               end
            end
            default: begin
               phase_in = PH_BETWEEN;
            end
         endcase

         // A byte that joins the word: quotes toggle, anything else is stored.
         if (take) begin
            phase_in = PH_WORD;
            priority if (c == CharSingleQ) begin
               squote_in = !squote_ff;
            end else if (c == CharDoubleQ) begin
               dquote_in = !dquote_ff;
            end else begin
               has_result        = 1'b1;
               result.out_char   = c;
               result.char_valid = 1'b1;
               if (count_inc >= cap) begin
                  result.word_end    = 1'b1;
                  result.word_length = count_inc;
                  phase_in           = PH_BETWEEN;
                  squote_in          = 1'b0;
                  dquote_in          = 1'b0;
                  count_in           = '0;
               end else begin
                  count_in = count_inc;
               end
            end
         end
      end
   end

endmodule

// ===== hdl/cwt_output_stage.sv =====
module cwt_output_stage
   import cwt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         can_take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         full_ff;
   logic         full_in;
   rsp_item_type item_ff;

   // A new result may enter when the register is empty or drains this cycle.
   assign can_take = !full_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         full_in = 1'b1;
      end else if (full_ff && !rsp_stall) begin
         full_in = 1'b0;
      end else begin
         full_in = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = full_ff;
   assign rsp_item  = item_ff;

endmodule
